### hw/rtl/tour_three_opt_move_core_assert.svh
// Assertion macros for the tour 3-opt move core.
`ifndef TOUR_THREE_OPT_MOVE_CORE_ASSERT_SVH
`define TOUR_THREE_OPT_MOVE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TOM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define TOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### hw/rtl/tom_pkg.sv
// ---------------------------------------------------------------------------
// tom_pkg
// Types, codes and constants shared by the tour 3-opt move core.
// ---------------------------------------------------------------------------
package tom_pkg;
   localparam int MAX_CITIES_DEF = 64;
   localparam int DIST_BITS_DEF  = 16;
   localparam int MIN_TOUR       = 6;
   localparam int GAIN_W         = 18;

   localparam logic [1:0] ADDR_TOUR_LENGTH = 2'd0;

   localparam logic [1:0] KIND_LOAD_DIST = 2'd0;
   localparam logic [1:0] KIND_LOAD_TOUR = 2'd1;
   localparam logic [1:0] KIND_MOVE      = 2'd2;
   localparam logic [1:0] KIND_READ      = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_CUTS  = 2'd1;
   localparam logic [1:0] ST_SHORT = 2'd2;

   localparam logic [2:0] VAR_BC = 3'b001;
   localparam logic [2:0] VAR_DE = 3'b010;
   localparam logic [2:0] VAR_BE = 3'b100;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  first_index;
      logic [5:0]  second_index;
      logic [5:0]  third_index;
      logic [15:0] load_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  chosen_variant;
      logic [17:0] gain;
      logic [5:0]  read_value;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_TRD, S_TWAIT, S_DRD, S_DWAIT, S_CMP, S_FRD, S_FWAIT, S_FWR, S_DONE
   } state_type;

   // Distance pair k (0..11) for the candidate cost table. Cities
   // 0..5 = A..F. Each cost uses three pairs; pairs are:
   // 0 AB 1 CD 2 EF 3 AC 4 BD 5 CE 6 DF 7 FB 8 EA 9 FC 10 BE 11 DA
   function automatic logic [5:0] pair_cities(input logic [3:0] k);
      logic [5:0] r;
      unique case (k)
         4'd0:    r = {3'd0, 3'd1};
         4'd1:    r = {3'd2, 3'd3};
         4'd2:    r = {3'd4, 3'd5};
         4'd3:    r = {3'd0, 3'd2};
         4'd4:    r = {3'd1, 3'd3};
         4'd5:    r = {3'd2, 3'd4};
         4'd6:    r = {3'd3, 3'd5};
         4'd7:    r = {3'd5, 3'd1};
         4'd8:    r = {3'd4, 3'd0};
         4'd9:    r = {3'd5, 3'd2};
         4'd10:   r = {3'd1, 3'd4};
         4'd11:   r = {3'd3, 3'd0};
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   // Pair indices making up variant v: {p0,p1,p2}.
   function automatic logic [11:0] variant_pairs(input logic [2:0] v);
      logic [11:0] r;
      unique case (v)
         3'd0:    r = {4'd0, 4'd1, 4'd2};
         3'd1:    r = {4'd3, 4'd4, 4'd2};
         3'd2:    r = {4'd0, 4'd5, 4'd6};
         3'd3:    r = {4'd3, 4'd10, 4'd6};
         3'd4:    r = {4'd7, 4'd1, 4'd8};
         3'd5:    r = {4'd9, 4'd4, 4'd8};
         3'd6:    r = {4'd7, 4'd5, 4'd11};
         default: r = {4'd9, 4'd10, 4'd11};
      endcase
      return r;
   endfunction

   // Try order after the identity: 1,2,4,3,6,5,7.
   function automatic logic [2:0] try_order(input logic [2:0] k);
      logic [2:0] r;
      unique case (k)
         3'd0:    r = 3'd1;
         3'd1:    r = 3'd2;
         3'd2:    r = 3'd4;
         3'd3:    r = 3'd3;
         3'd4:    r = 3'd6;
         3'd5:    r = 3'd5;
         default: r = 3'd7;
      endcase
      return r;
   endfunction
endpackage

### hw/rtl/tom_dist_mem.sv
// ---------------------------------------------------------------------------
// tom_dist_mem
// Distance matrix memory, one write and one registered read port.
// ---------------------------------------------------------------------------
module tom_dist_mem
   import tom_pkg::*;
#(
   parameter int MAX_CITIES = MAX_CITIES_DEF,
   parameter int DIST_BITS  = DIST_BITS_DEF,
   localparam int AW = 2 * $clog2(MAX_CITIES)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DIST_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [DIST_BITS-1:0] rd_data
);
   logic [DIST_BITS-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hw/rtl/tour_three_opt_move_core.sv
// ---------------------------------------------------------------------------
// tour_three_opt_move_core
// 3-opt local search move engine on a closed tour held in memory.
// ---------------------------------------------------------------------------
// Usage: set tour_length through the csr_ port (address 0), then load the
// distance matrix (kind 0) and tour positions 0..n (kind 1) as requests on
// req_ with req_start; a request is taken when req_start is high and
// req_busy low. Kind 3 reads a tour position, kind 2 tries a move.
// Every request gives one response with rsp_valid high for one cycle; the
// receiver cannot stall. One request at a time; req_busy drops in the
// cycle that carries the response.
// A move reads six tour cities through the one tour read port, then 12
// distances through the one distance read port, then compares each
// candidate cost in turn, then swaps elements one pair at a time (at
// most n-1 pairs).
// Reset clears control and tour_length; memories are undefined until
// written.
// ---------------------------------------------------------------------------
module tour_three_opt_move_core
   import tom_pkg::*;
#(
   parameter int MAX_CITIES = MAX_CITIES_DEF,
   parameter int DIST_BITS  = DIST_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  req_type     req_data,
   output logic        req_busy,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   `include "tour_three_opt_move_core_assert.svh"

   localparam int CB  = $clog2(MAX_CITIES);
   localparam int TW  = $clog2(MAX_CITIES + 1);
   localparam int AW  = 2 * CB;
   localparam int CW  = DIST_BITS + 2;

   // configuration
   logic [6:0] tour_length_ff, tour_length_in;
   assign csr_pready = 1'b1;
   always_comb begin
      tour_length_in = tour_length_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_TOUR_LENGTH)
         tour_length_in = csr_pwdata[6:0];
   end
   assign csr_prdata = (csr_paddr == ADDR_TOUR_LENGTH) ? {25'd0, tour_length_ff} : 32'd0;

   // tour memory
   logic [5:0]    tour_mem [MAX_CITIES + 1];
   logic          t_we;
   logic [TW-1:0] t_waddr, t_raddr;
   logic [5:0]    t_wdata, t_rdata_ff;
   always_ff @(posedge clock) begin
      if (t_we) tour_mem[t_waddr] <= t_wdata;
      t_rdata_ff <= tour_mem[t_raddr];
   end

   // distance memory
   logic                 d_we;
   logic [AW-1:0]        d_waddr, d_raddr;
   logic [DIST_BITS-1:0] d_rdata;
   tom_dist_mem #(.MAX_CITIES(MAX_CITIES), .DIST_BITS(DIST_BITS)) u_dist (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (req_data.load_value[DIST_BITS-1:0]),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [6:0] a_ff, c_ff, e_ff;
   logic [5:0] city_ff [6];
   logic       zero_ff [6];  // city out of matrix -> cost 0
   logic [DIST_BITS-1:0] pd_ff [12];
   logic       pz_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic [CW-1:0] best_ff, base_ff;
   logic [2:0] var_ff;
   logic [1:0] fphase_ff;       // which flip is running
   logic [6:0] lo_ff, hi_ff;
   logic [5:0] tmp_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // sorted cuts
   logic [6:0] s0, s1, s2, x0, x1, x2, ncl;
   always_comb begin
      x0 = req_data.first_index;
      x1 = {1'b0, req_data.second_index};
      x2 = {1'b0, req_data.third_index};
      s0 = x0; s1 = x1; s2 = x2;
      if (s0 > s1) begin s0 = x1; s1 = x0; end
      if (s0 > s2) begin x0 = s0; s0 = s2; s2 = x0; end
      if (s1 > s2) begin x1 = s1; s1 = s2; s2 = x1; end
      ncl = (tour_length_ff > 7'(MAX_CITIES)) ? 7'(MAX_CITIES) : tour_length_ff;
   end

   logic go;
   assign go = req_start && !req_busy;
   assign req_busy = (state_ff != S_IDLE);

   // tour read address per phase
   logic [6:0] tpos;
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0:    tpos = a_ff;
         3'd1:    tpos = a_ff + 7'd1;
         3'd2:    tpos = c_ff;
         3'd3:    tpos = c_ff + 7'd1;
         3'd4:    tpos = e_ff;
         default: tpos = e_ff + 7'd1;
      endcase
   end

   // candidate cost for variant chosen by cnt
   logic [2:0]  cv;
   logic [11:0] vp;
   logic [CW-1:0] ccost;
   assign cv = try_order(cnt_ff[2:0]);
   assign vp = variant_pairs(cv);
   assign ccost = CW'(pd_ff[vp[11:8]]) + CW'(pd_ff[vp[7:4]]) + CW'(pd_ff[vp[3:0]]);

   logic [5:0] pc;
   logic [2:0] pu, pv;
   assign pc = pair_cities(cnt_ff);
   assign pu = pc[5:3];
   assign pv = pc[2:0];

   // next flip selection
   logic [2:0] fvar;
   always_comb begin
      unique case (fphase_ff)
         2'd0:    fvar = VAR_BC;
         2'd1:    fvar = VAR_DE;
         default: fvar = VAR_BE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (go) begin
            priority case (req_data.kind)
               KIND_READ: state_in = S_TRD;
               KIND_MOVE: state_in = (ncl < 7'(MIN_TOUR) || s2 >= ncl ||
                                      s1 < s0 + 7'd2 || s2 < s1 + 7'd2) ? S_DONE : S_TRD;
               default:   state_in = S_DONE;
            endcase
         end
         S_TRD:   state_in = S_TWAIT;
         S_TWAIT: state_in = (req_ff.kind == KIND_READ) ? S_DONE :
                             (cnt_ff == 4'd5) ? S_DRD : S_TRD;
         S_DRD:   state_in = S_DWAIT;
         S_DWAIT: state_in = (cnt_ff == 4'd11) ? S_CMP : S_DRD;
         S_CMP:   state_in = (cnt_ff == 4'd6) ? S_FRD : S_CMP;
         S_FRD:   state_in = (fphase_ff == 2'd3) ? S_DONE :
                             ((var_ff & fvar) == 3'd0 || lo_ff >= hi_ff) ? S_FRD : S_FWAIT;
         S_FWAIT: state_in = S_FWR;
         S_FWR:   state_in = S_FRD;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs / datapath controls
   always_comb begin
      t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
      d_we = 1'b0; d_waddr = '0; d_raddr = '0;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            rsp_in = '0;
            if (go && req_data.kind == KIND_LOAD_DIST &&
                req_data.first_index < 7'(MAX_CITIES) &&
                7'(req_data.second_index) < 7'(MAX_CITIES)) begin
               d_we = 1'b1;
               d_waddr = {req_data.first_index[CB-1:0], req_data.second_index[CB-1:0]};
            end
            if (go && req_data.kind == KIND_LOAD_TOUR &&
                req_data.first_index <= 7'(MAX_CITIES)) begin
               t_we = 1'b1;
               t_waddr = TW'(req_data.first_index);
               t_wdata = req_data.load_value[5:0];
            end
            if (go && req_data.kind == KIND_MOVE) begin
               if (ncl < 7'(MIN_TOUR)) rsp_in.status = ST_SHORT;
               else if (s2 >= ncl || s1 < s0 + 7'd2 || s2 < s1 + 7'd2)
                  rsp_in.status = ST_CUTS;
            end
         end
         S_TRD: t_raddr = (req_ff.kind == KIND_READ) ? TW'(req_ff.first_index) : TW'(tpos);
         S_TWAIT: begin
            if (req_ff.kind == KIND_READ)
               rsp_in.read_value = (req_ff.first_index <= 7'(MAX_CITIES)) ? t_rdata_ff : 6'd0;
            cnt_in = (cnt_ff == 4'd5) ? 4'd0 : cnt_ff + 4'd1;
         end
         S_DRD: d_raddr = {city_ff[pu][CB-1:0], city_ff[pv][CB-1:0]};
         S_DWAIT: cnt_in = (cnt_ff == 4'd11) ? 4'd0 : cnt_ff + 4'd1;
         S_CMP: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd6) begin
               rsp_in.chosen_variant = (ccost < best_ff) ? cv : var_ff;
               rsp_in.gain = GAIN_W'(base_ff - ((ccost < best_ff) ? ccost : best_ff));
            end
         end
         S_FRD: t_raddr = TW'(lo_ff);
         S_FWAIT: t_raddr = TW'(hi_ff);
         S_FWR: begin
            t_we = 1'b1; t_waddr = TW'(lo_ff); t_wdata = t_rdata_ff;
         end
         default: rsp_valid_in = 1'b1;
      endcase
      // second half of swap: write saved lo value to hi while reading next lo
      if (state_ff == S_FRD && fphase_ff != 2'd3 && lo_ff > 7'd0 && pz_ff) begin
         t_we = 1'b1; t_waddr = TW'(hi_ff + 7'd1); t_wdata = tmp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tour_length_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         pz_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tour_length_ff <= tour_length_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         pz_ff <= (state_ff == S_FWR);
      end
      rsp_ff <= rsp_in;
      if (state_ff == S_IDLE) begin
         req_ff <= req_data;
         a_ff <= s0; c_ff <= s1; e_ff <= s2;
         fphase_ff <= 2'd0;
      end
      if (state_ff == S_TWAIT && req_ff.kind == KIND_MOVE) begin
         city_ff[cnt_ff[2:0]] <= t_rdata_ff;
         zero_ff[cnt_ff[2:0]] <= (7'(t_rdata_ff) >= 7'(MAX_CITIES));
      end
      if (state_ff == S_DWAIT)
         pd_ff[cnt_ff] <= (zero_ff[pu] || zero_ff[pv]) ? '0 : d_rdata;
      if (state_ff == S_DWAIT && cnt_ff == 4'd11) begin
         // current cost AB+CD+EF: pairs 0..2 are already stored
         base_ff <= CW'(pd_ff[0]) + CW'(pd_ff[1]) + CW'(pd_ff[2]);
         best_ff <= CW'(pd_ff[0]) + CW'(pd_ff[1]) + CW'(pd_ff[2]);
         var_ff <= 3'd0;
      end
      if (state_ff == S_CMP && ccost < best_ff) begin
         best_ff <= ccost;
         var_ff <= cv;
      end
      if (state_ff == S_CMP && cnt_ff == 4'd6) begin
         if (ccost < best_ff) var_ff <= cv;
         lo_ff <= a_ff + 7'd1; hi_ff <= c_ff;
      end
      if (state_ff == S_FRD) begin
         if (fphase_ff != 2'd3 && ((var_ff & fvar) == 3'd0 || lo_ff >= hi_ff)) begin
            fphase_ff <= fphase_ff + 2'd1;
            unique case (fphase_ff)
               2'd0:    begin lo_ff <= c_ff + 7'd1; hi_ff <= e_ff; end
               default: begin lo_ff <= a_ff + 7'd1; hi_ff <= e_ff; end
            endcase
         end
      end
      if (state_ff == S_FWAIT) tmp_ff <= t_rdata_ff;
      if (state_ff == S_FWR) begin
         lo_ff <= lo_ff + 7'd1; hi_ff <= hi_ff - 7'd1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TOM_ASSERT_IMP(a_busy_rsp, clock, reset, rsp_valid, !req_busy,
                   "response while busy")
   `TOM_ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == S_DONE, rsp_valid && !req_busy,
                    "done did not give one response")
   `TOM_ASSERT_IMP(a_status_var, clock, reset, rsp_valid && rsp_data.status != ST_OK,
                   rsp_data.chosen_variant == 3'd0 && rsp_data.gain == '0,
                   "failed move reports a variant")
endmodule
